>>> design/cfd_pkg.sv
// shared types and constants for the command frame decoder
// no dependencies; imported by cfd_decode and command_frame_decoder
package cfd_pkg;

  // framing bytes
  localparam logic [7:0] SYNC_BYTE = 8'hAE;
  localparam logic [7:0] ACK_BYTE  = 8'hAA;

  // command group codes in frame byte 2
  localparam logic [7:0] GRP_KEYS = 8'h01;
  localparam logic [7:0] GRP_USB  = 8'h02;
  localparam logic [7:0] GRP_DLC  = 8'h03;
  localparam logic [7:0] GRP_SYS  = 8'h04;

  // argument codes in frame byte 3
  localparam logic [7:0] ARG_ALL     = 8'hFF;
  localparam logic [7:0] ARG_KEY_LO  = 8'h01;
  localparam logic [7:0] ARG_KEY_HI  = 8'h09;
  localparam logic [7:0] ARG_KEY_9   = 8'h10;
  localparam logic [7:0] ARG_KEY_10  = 8'h11;
  localparam logic [7:0] ARG_CHANGE  = 8'h02;
  localparam logic [7:0] ARG_OFF     = 8'h00;
  localparam logic [7:0] ARG_ON      = 8'h01;

  // target codes in frame byte 1
  localparam logic [7:0] TGT_SYS     = 8'h00;
  localparam logic [7:0] TGT_TOOL_LO = 8'h01;
  localparam logic [7:0] TGT_TOOL_HI = 8'h03;

  // fixed key indices for the two extended keys
  localparam logic [3:0] KEY_IDX_9  = 4'd9;
  localparam logic [3:0] KEY_IDX_10 = 4'd10;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_ALL_KEYS = 4'd1,
    ACT_ONE_KEY  = 4'd2,
    ACT_CHANGE   = 4'd3,
    ACT_STOP     = 4'd4,
    ACT_USB_OFF  = 4'd5,
    ACT_USB_ON   = 4'd6,
    ACT_DLC_OFF  = 4'd7,
    ACT_DLC_ON   = 4'd8
  } cfd_action_t;

  // decoded command
  typedef struct packed {
    cfd_action_t action;
    logic [3:0]  key_number;
    logic [1:0]  tool_number;
  } cfd_cmd_t;

endpackage

>>> design/cfd_decode.sv
// combinational decode of frame bytes 1..3 into an action with key and tool indices
// depends on cfd_pkg
module cfd_decode (
  input  logic [7:0]        b1,
  input  logic [7:0]        b2,
  input  logic [7:0]        b3,
  input  logic              enabled,
  output cfd_pkg::cfd_cmd_t cmd
);
  import cfd_pkg::*;

  cfd_cmd_t   raw;
  logic [7:0] key_sub;
  logic [7:0] tool_sub;

  assign key_sub  = b3 - ARG_KEY_LO;
  assign tool_sub = b1 - TGT_TOOL_LO;

  // frame decode
  always_comb begin
    raw.action      = ACT_NONE;
    raw.key_number  = '0;
    raw.tool_number = '0;
    if (b1 == TGT_SYS && b2 == GRP_KEYS) begin
      unique case (b3) inside
        ARG_ALL: begin
          raw.action = ACT_ALL_KEYS;
        end
        [ARG_KEY_LO:ARG_KEY_HI]: begin
          raw.action     = ACT_ONE_KEY;
          raw.key_number = key_sub[3:0];
        end
        ARG_KEY_9: begin
          raw.action     = ACT_ONE_KEY;
          raw.key_number = KEY_IDX_9;
        end
        ARG_KEY_10: begin
          raw.action     = ACT_ONE_KEY;
          raw.key_number = KEY_IDX_10;
        end
        default: begin
          raw.action = ACT_NONE;
        end
      endcase
    end else if (b1 == TGT_SYS && b2 == GRP_SYS) begin
      unique case (b3)
        ARG_CHANGE: raw.action = ACT_CHANGE;
        ARG_OFF:    raw.action = ACT_STOP;
        default:    raw.action = ACT_NONE;
      endcase
    end else if (b1 >= TGT_TOOL_LO && b1 <= TGT_TOOL_HI) begin
      // tool index only given with a recognised usb or dlc command
      if ((b2 == GRP_USB || b2 == GRP_DLC) && (b3 == ARG_OFF || b3 == ARG_ON)) begin
        raw.tool_number = tool_sub[1:0];
        if (b2 == GRP_USB) begin
          raw.action = (b3 == ARG_ON) ? ACT_USB_ON : ACT_USB_OFF;
        end else begin
          raw.action = (b3 == ARG_ON) ? ACT_DLC_ON : ACT_DLC_OFF;
        end
      end
    end
  end

  // commands disabled gives no action
  always_comb begin
    if (enabled) begin
      cmd = raw;
    end else begin
      cmd.action      = ACT_NONE;
      cmd.key_number  = '0;
      cmd.tool_number = '0;
    end
  end

endmodule

>>> design/command_frame_decoder.sv
// top level of the command frame decoder: byte framing, frame register and result register
// depends on cfd_pkg and cfd_decode
//
// Takes one received byte per beat and gathers four-byte command frames; a byte of
// 0xAE always restarts the frame as its (ignored) first byte. A byte can be offered
// in every cycle while in_stall is low. A completed frame is held in a frame
// register, decoded combinationally from it and then given from the result register
// as a single result beat (acknowledge 0xAA, echo of frame bytes 1 to 3, action, key
// and tool index). Bytes that do not complete a frame give no result. The frame
// register lets one further completed frame be taken while a result is held by
// out_stall; in_stall rises only when both are full.
module command_frame_decoder (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       commands_enabled,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] ack_lead,
  output logic [7:0] ack_second,
  output logic [7:0] ack_third,
  output logic [7:0] ack_fourth,
  output logic [3:0] action,
  output logic [3:0] key_number,
  output logic [1:0] tool_number
);
  import cfd_pkg::*;

  // framing state
  logic [1:0] frame_position;
  logic [7:0] frame_store [2];

  // frame register
  logic       frame_valid;
  logic [7:0] frame_b1;
  logic [7:0] frame_b2;
  logic [7:0] frame_b3;
  logic       frame_enabled;

  // result register
  cfd_cmd_t   result_cmd;
  cfd_cmd_t   dec_cmd;

  logic       in_take;
  logic       out_free;
  logic       frame_move;
  logic [1:0] pos;
  logic       frame_done;

  // handshake
  assign out_free   = !out_valid || !out_stall;
  assign frame_move = frame_valid && out_free;
  assign in_stall   = frame_valid && !out_free;
  assign in_take    = in_valid && !in_stall;

  // position of the incoming byte
  assign pos        = (rx_byte == SYNC_BYTE) ? 2'd0 : frame_position;
  assign frame_done = (pos == 2'd3);

  // frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= 2'd0;
    end else if (in_take) begin
      frame_position <= frame_done ? 2'd0 : pos + 2'd1;
    end
  end

  // bytes 1 and 2 of the frame being gathered
  always_ff @(posedge clk) begin
    if (in_take && pos == 2'd1) begin
      frame_store[0] <= rx_byte;
    end
    if (in_take && pos == 2'd2) begin
      frame_store[1] <= rx_byte;
    end
  end

  // frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (in_take && frame_done) begin
      frame_valid <= 1'b1;
    end else if (frame_move) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && frame_done) begin
      frame_b1      <= frame_store[0];
      frame_b2      <= frame_store[1];
      frame_b3      <= rx_byte;
      frame_enabled <= commands_enabled;
    end
  end

  // decode
  cfd_decode u_decode (
    .b1      (frame_b1),
    .b2      (frame_b2),
    .b3      (frame_b3),
    .enabled (frame_enabled),
    .cmd     (dec_cmd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_move) begin
      ack_second <= frame_b1;
      ack_third  <= frame_b2;
      ack_fourth <= frame_b3;
      result_cmd <= dec_cmd;
    end
  end

  assign ack_lead    = ACK_BYTE;
  assign action      = result_cmd.action;
  assign key_number  = result_cmd.key_number;
  assign tool_number = result_cmd.tool_number;

endmodule

>>> sim/tb_command_frame_decoder.sv
// self-checking testbench for command_frame_decoder: byte stream in, acknowledge beats out
// depends on cfd_pkg and the command_frame_decoder rtl; reads nothing else
module tb_command_frame_decoder;
  import cfd_pkg::*;

  localparam int BYTE_TARGET = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 16;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       commands_enabled;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] ack_lead;
  logic [7:0] ack_second;
  logic [7:0] ack_third;
  logic [7:0] ack_fourth;
  logic [3:0] action;
  logic [3:0] key_number;
  logic [1:0] tool_number;

  // one acknowledge beat as seen on the result port
  typedef struct {
    logic [7:0]  lead;
    logic [7:0]  second;
    logic [7:0]  third;
    logic [7:0]  fourth;
    cfd_action_t act;
    logic [3:0]  key;
    logic [1:0]  tool;
  } frame_ack_t;

  // framing and decode tracker, holds the acknowledges still owed by the block
  class cfd_ack_tracker;
    logic [1:0] position;
    logic [7:0] held [3];
    frame_ack_t pending_acks [$];
    int bytes_taken;
    int acks_checked;
    int commands_seen;
    int sync_breaks;
    int mismatches;

    function new();
      position = 2'd0;
      foreach (held[i]) held[i] = 8'h00;
      bytes_taken = 0;
      acks_checked = 0;
      commands_seen = 0;
      sync_breaks = 0;
      mismatches = 0;
    endfunction

    function frame_ack_t decode_frame(logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
      frame_ack_t a;
      logic [7:0] idx;
      a.lead = ACK_BYTE;
      a.second = b1;
      a.third = b2;
      a.fourth = b3;
      a.act = ACT_NONE;
      a.key = 4'd0;
      a.tool = 2'd0;
      if (b1 == TGT_SYS && b2 == GRP_KEYS) begin
        if (b3 == ARG_ALL) begin
          a.act = ACT_ALL_KEYS;
        end else if (b3 >= ARG_KEY_LO && b3 <= ARG_KEY_HI) begin
          idx = b3 - ARG_KEY_LO;
          a.act = ACT_ONE_KEY;
          a.key = idx[3:0];
        end else if (b3 == ARG_KEY_9) begin
          a.act = ACT_ONE_KEY;
          a.key = KEY_IDX_9;
        end else if (b3 == ARG_KEY_10) begin
          a.act = ACT_ONE_KEY;
          a.key = KEY_IDX_10;
        end
      end else if (b1 == TGT_SYS && b2 == GRP_SYS) begin
        if (b3 == ARG_CHANGE) a.act = ACT_CHANGE;
        else if (b3 == ARG_OFF) a.act = ACT_STOP;
      end else if (b1 >= TGT_TOOL_LO && b1 <= TGT_TOOL_HI) begin
        if (b2 == GRP_USB && b3 == ARG_OFF) a.act = ACT_USB_OFF;
        else if (b2 == GRP_USB && b3 == ARG_ON) a.act = ACT_USB_ON;
        else if (b2 == GRP_DLC && b3 == ARG_OFF) a.act = ACT_DLC_OFF;
        else if (b2 == GRP_DLC && b3 == ARG_ON) a.act = ACT_DLC_ON;
        if (a.act != ACT_NONE) begin
          idx = b1 - TGT_TOOL_LO;
          a.tool = idx[1:0];
        end
      end
      return a;
    endfunction

    // accepted input beat: advance framing, queue an acknowledge on the fourth byte
    function void note_byte(logic [7:0] b, logic en);
      logic [1:0] at;
      frame_ack_t a;
      bytes_taken++;
      at = position;
      if (b == SYNC_BYTE) begin
        if (at != 2'd0) sync_breaks++;
        at = 2'd0;
      end
      if (at != 2'd0) held[at - 2'd1] = b;
      if (at != 2'd3) begin
        position = at + 2'd1;
        return;
      end
      position = 2'd0;
      a = decode_frame(held[0], held[1], held[2]);
      if (!en) begin
        a.act = ACT_NONE;
        a.key = 4'd0;
        a.tool = 2'd0;
      end
      if (a.act != ACT_NONE) commands_seen++;
      pending_acks.push_back(a);
    endfunction

    // accepted result beat: compare against the oldest owed acknowledge
    function void check_ack(frame_ack_t got);
      frame_ack_t want;
      if (pending_acks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: %h %h %h %h act=%0d key=%0d tool=%0d",
                   got.lead, got.second, got.third, got.fourth, got.act, got.key, got.tool);
        return;
      end
      want = pending_acks.pop_front();
      acks_checked++;
      if (got.lead !== want.lead || got.second !== want.second ||
          got.third !== want.third || got.fourth !== want.fourth ||
          got.act !== want.act || got.key !== want.key || got.tool !== want.tool) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ack %0d mismatch", acks_checked);
          $display("  expected %h %h %h %h act=%0d key=%0d tool=%0d",
                   want.lead, want.second, want.third, want.fourth,
                   want.act, want.key, want.tool);
          $display("  actual   %h %h %h %h act=%0d key=%0d tool=%0d",
                   got.lead, got.second, got.third, got.fourth, got.act, got.key, got.tool);
        end
      end
    endfunction

    function int outstanding();
      return pending_acks.size();
    endfunction
  endclass

  cfd_ack_tracker book;
  int  cycles;
  int  bytes_sent;
  bit  sender_quiet;
  bit  receiver_quiet;

  command_frame_decoder dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .commands_enabled (commands_enabled),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .ack_lead         (ack_lead),
    .ack_second       (ack_second),
    .ack_third        (ack_third),
    .ack_fourth       (ack_fourth),
    .action           (action),
    .key_number       (key_number),
    .tool_number      (tool_number)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // offer one byte after a random gap and hold it until the beat is taken
  task automatic send_beat(input logic [7:0] b, input logic en);
    int gap;
    if (bytes_sent % 50 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
    gap = draw_wait(sender_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    commands_enabled <= en;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
    book.note_byte(b, en);
    bytes_sent++;
  endtask

  // four bytes; only the enable on the last one decides the action
  task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3, input logic en);
    send_beat(b0, 1'($urandom_range(0, 1)));
    send_beat(b1, 1'($urandom_range(0, 1)));
    send_beat(b2, 1'($urandom_range(0, 1)));
    send_beat(b3, en);
  endtask

  // hold off the sender until every owed acknowledge has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.outstanding() != 0) @(posedge clk);
  endtask

  // random command-like frame body
  task automatic pick_body(output logic [7:0] b1, output logic [7:0] b2,
                           output logic [7:0] b3);
    b1 = 8'($urandom_range(0, 255));
    b2 = 8'($urandom_range(0, 255));
    b3 = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: begin b1 = TGT_SYS; b2 = GRP_KEYS; b3 = ARG_ALL; end
      1: begin b1 = TGT_SYS; b2 = GRP_KEYS; b3 = 8'($urandom_range(1, 9)); end
      2: begin b1 = TGT_SYS; b2 = GRP_KEYS; b3 = $urandom_range(0, 1) ? ARG_KEY_9 : ARG_KEY_10; end
      3: begin
        b1 = TGT_SYS;
        b2 = GRP_SYS;
        b3 = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) :
             ($urandom_range(0, 1) ? ARG_CHANGE : ARG_OFF);
      end
      4, 5: begin
        b1 = 8'($urandom_range(1, 3));
        b2 = $urandom_range(0, 1) ? GRP_USB : GRP_DLC;
        b3 = 8'($urandom_range(0, 1));
      end
      6: begin
        b1 = 8'($urandom_range(0, 4));
        b2 = 8'($urandom_range(0, 5));
        b3 = 8'($urandom_range(0, 18));
      end
      7: begin b1 = TGT_SYS; b2 = GRP_KEYS; end
      default: ;
    endcase
  endtask

  // result side: random stall before each beat, check on acceptance
  initial begin : result_side
    int hold;
    int taken;
    frame_ack_t got;
    taken = 0;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (taken % 16 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
      hold = draw_wait(receiver_quiet);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      got.lead = ack_lead;
      got.second = ack_second;
      got.third = ack_third;
      got.fourth = ack_fourth;
      got.act = cfd_action_t'(action);
      got.key = key_number;
      got.tool = tool_number;
      book.check_ack(got);
      taken++;
    end
  end

  // stimulus and end of run
  initial begin : byte_source
    logic [7:0] b1, b2, b3, lead;
    logic       en;
    int         sel;
    int         n;
    bit         paused;
    book = new();
    cycles = 0;
    bytes_sent = 0;
    paused = 1'b0;
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_byte <= 8'h00;
    commands_enabled <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames: each command group, disabled commands, sync inside a frame
    send_frame(SYNC_BYTE, TGT_SYS, GRP_KEYS, ARG_ALL, 1'b1);
    send_frame(SYNC_BYTE, TGT_SYS, GRP_KEYS, ARG_KEY_10, 1'b1);
    send_frame(SYNC_BYTE, TGT_SYS, GRP_SYS, ARG_CHANGE, 1'b1);
    send_frame(SYNC_BYTE, TGT_SYS, GRP_SYS, ARG_OFF, 1'b1);
    send_frame(SYNC_BYTE, TGT_TOOL_HI, GRP_DLC, ARG_ON, 1'b1);
    send_frame(SYNC_BYTE, TGT_TOOL_LO, GRP_USB, ARG_OFF, 1'b0);
    // partial frame cut by a sync byte, then an unrecognised all-ones body
    send_beat(8'h00, 1'b1);
    send_frame(SYNC_BYTE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    drain();

    // random traffic: mostly well-formed frames, some broken frames and noise
    while (bytes_sent < BYTE_TARGET) begin
      if (!paused && bytes_sent >= BYTE_TARGET / 2) begin
        drain();
        paused = 1'b1;
      end
      sel = $urandom_range(0, 9);
      pick_body(b1, b2, b3);
      en = ($urandom_range(0, 7) != 0);
      if (sel <= 6) begin
        lead = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : SYNC_BYTE;
        send_frame(lead, b1, b2, b3, en);
      end else if (sel == 7) begin
        // frame start that the next sync byte will cut short
        send_beat(SYNC_BYTE, en);
        n = $urandom_range(0, 2);
        if (n > 0) send_beat(b1, en);
        if (n > 1) send_beat(b2, en);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end

    in_valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d bytes, %0d acknowledges checked, %0d carrying a command",
             book.bytes_taken, book.acks_checked, book.commands_seen);
    $display("%0d partial frames were cut short by a sync byte; %0d mismatches",
             book.sync_breaks, book.mismatches + book.outstanding());
    if (book.mismatches == 0 && book.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
design/cfd_pkg.sv
design/cfd_decode.sv
design/command_frame_decoder.sv
sim/tb_command_frame_decoder.sv
